/* sv/mbh_pkg.sv */
`timescale 1ns / 1ps
// mbh_pkg: shared constants for the 2x2 box-filter mip level downsampler.
// Used by mipmap_box_halving and its port checker; depends on nothing.
package mbh_pkg;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int MAX_CHANNELS   = 4;

	localparam int NUM_CH    = 4;
	localparam int CH_W      = 8;
	localparam int SUM_W     = CH_W + 1;
	localparam int PIX_W     = NUM_CH * CH_W;
	localparam int PSUM_W    = NUM_CH * SUM_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 13;
	localparam int NCH_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;

endpackage

/* sv/mipmap_box_halving.sv */
`timescale 1ns / 1ps
// A result word is registered in stage 1 and then in the output register before m_tvalid.
// Throughput: one source pixel per cycle unless the output stalls; the single-port line store
// of pair sums is written on even source rows, read on odd ones, one access per pixel pair.
// Reset (arst_n low): 2x2 image, four channels, raster position zero, both stages empty.
// The line store has no reset; every entry is written on an even row before it is read.
// mipmap_box_halving: streaming 2x2 box-filter downsampler producing the next mip level.
// Depends on mbh_pkg.
module mipmap_box_halving
	import mbh_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [PIX_W-1:0]     s_tdata,   // channel_0, channel_1, channel_2, channel_3
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [PIX_W-1:0]     m_tdata,   // result_0, result_1, result_2, result_3
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int WW         = $clog2(MAX_WIDTH + 1);
	localparam int HW         = $clog2(MAX_HEIGHT + 1);
	localparam int LW         = (WW > HW) ? WW : HW;
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	logic [WW-1:0]    w_q, col_q, w_wr, w_end;
	logic [HW-1:0]    h_q, row_q, h_wr, h_end;
	logic [NCH_W-1:0] nch_q, nch_wr;
	logic [PIX_W-1:0] held_q;

	logic [PSUM_W-1:0] line_mem [LINE_DEPTH];

	logic [CH_W-1:0]  chan [NUM_CH];
	logic [PIX_W-1:0] pix, avg2;
	logic [PSUM_W-1:0] psum;
	logic [LW-1:0]    lin_len, lin_idx, lin_end;
	logic             w_one, h_one, pass, one_d, lin_in, box_in;
	logic             acc, held_en, box_pair, wr_en, rd_en, res, last_s0;
	logic [AW-1:0]    slot;
	logic             out_free;

	logic              v_s1, box_s1, last_s1;
	logic [PIX_W-1:0]  byte_s1;
	logic [PSUM_W-1:0] sum_s1, above_s1;
	logic [PIX_W-1:0]  box_avg;
	logic [SUM_W:0]    quad;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (cfg_data == '0)
			w_wr = WW'(1);
		else if (32'(cfg_data) > 32'(MAX_WIDTH))
			w_wr = WW'(MAX_WIDTH);
		else
			w_wr = WW'(cfg_data);
		if (cfg_data == '0)
			h_wr = HW'(1);
		else if (32'(cfg_data) > 32'(MAX_HEIGHT))
			h_wr = HW'(MAX_HEIGHT);
		else
			h_wr = HW'(cfg_data);
		if (cfg_data[NCH_W-1:0] == '0)
			nch_wr = NCH_W'(1);
		else if (cfg_data[NCH_W-1:0] > NCH_W'(MAX_CHANNELS))
			nch_wr = NCH_W'(MAX_CHANNELS);
		else
			nch_wr = cfg_data[NCH_W-1:0];
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			chan[c] = (NCH_W'(c) < nch_q) ? s_tdata[c*CH_W +: CH_W] : '0;
			pix[c*CH_W +: CH_W] = chan[c];
			psum[c*SUM_W +: SUM_W] = {1'b0, held_q[c*CH_W +: CH_W]} + {1'b0, chan[c]};
			avg2[c*CH_W +: CH_W] = psum[c*SUM_W+1 +: CH_W];
		end
	end

	always_comb begin
		w_one   = (w_q == WW'(1));
		h_one   = (h_q == HW'(1));
		pass    = w_one && h_one;
		one_d   = (w_one || h_one) && !pass;
		lin_len = w_one ? LW'(h_q) : LW'(w_q);
		lin_idx = w_one ? LW'(row_q) : LW'(col_q);
		lin_end = {lin_len[LW-1:1], 1'b0};
		lin_in  = (lin_idx < lin_end);
		w_end   = {w_q[WW-1:1], 1'b0};
		h_end   = {h_q[HW-1:1], 1'b0};
		box_in  = (col_q < w_end) && (row_q < h_end);
		slot    = AW'(col_q >> 1);

		acc      = s_tvalid && s_tready;
		box_pair = acc && !w_one && !h_one && box_in && col_q[0];
		wr_en    = box_pair && !row_q[0];
		rd_en    = box_pair && row_q[0];
		held_en  = acc && (one_d ? (lin_in && !lin_idx[0])
			: (!w_one && !h_one && box_in && !col_q[0]));
		res      = (acc && (pass || (one_d && lin_in && lin_idx[0]))) || rd_en;

		if (pass)
			last_s0 = 1'b1;
		else if (one_d)
			last_s0 = (lin_idx == lin_end - LW'(1));
		else
			last_s0 = (row_q == h_end - HW'(1)) && (col_q == w_end - WW'(1));
	end

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = !v_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= WW'(2);
			h_q    <= HW'(2);
			nch_q  <= NCH_W'(MAX_CHANNELS);
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:    w_q   <= w_wr;
				REG_HEIGHT:   h_q   <= h_wr;
				REG_CHANNELS: nch_q <= nch_wr;
				default: ;
			endcase
			if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
				|| cfg_index == REG_CHANNELS) begin
				col_q <= '0;
				row_q <= '0;
			end
		end else if (acc) begin
			if (held_en)
				held_q <= pix;
			if (col_q == w_q - WW'(1)) begin
				col_q <= '0;
				row_q <= (row_q == h_q - HW'(1)) ? '0 : row_q + HW'(1);
			end else begin
				col_q <= col_q + WW'(1);
			end
		end
	end

	// line store of horizontal pair sums
	always_ff @(posedge clk) begin
		if (wr_en)
			line_mem[slot] <= psum;
		if (rd_en)
			above_s1 <= line_mem[slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (s_tready)
			v_s1 <= res;
	end

	always_ff @(posedge clk) begin
		if (res) begin
			box_s1  <= rd_en;
			last_s1 <= last_s0;
			byte_s1 <= pass ? pix : avg2;
			sum_s1  <= psum;
		end
	end

	always_comb begin
		quad = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			quad = {1'b0, above_s1[c*SUM_W +: SUM_W]} + {1'b0, sum_s1[c*SUM_W +: SUM_W]};
			box_avg[c*CH_W +: CH_W] = quad[SUM_W:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (out_free)
			m_tvalid <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s1) begin
			m_tdata <= box_s1 ? box_avg : byte_s1;
			m_tlast <= last_s1;
		end
	end

endmodule

/* sv/mbh_checker.sv */
`timescale 1ns / 1ps
// mbh_checker: port-level checks on mipmap_box_halving, bound to the top level.
// Depends on mbh_pkg.
module mbh_checker
	import mbh_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [PIX_W-1:0]     m_tdata,   // result_0, result_1, result_2, result_3
	input logic                 m_tlast,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DAT_W-1:0] cfg_data
);

	logic one_ch_q;

	// channel register written with one: upper result bytes must read zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			one_ch_q <= 1'b0;
		else if (cfg_valid && cfg_ready && cfg_index == REG_CHANNELS)
			one_ch_q <= (cfg_data[NCH_W-1:0] == NCH_W'(1));
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && one_ch_q |-> m_tdata[PIX_W-1:CH_W] == '0)
		else $error("unused channel nonzero");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config word refused");

endmodule

bind mipmap_box_halving mbh_checker u_mbh_checker (.*);

/* tb/mipmap_box_halving_tb.sv */
`timescale 1ns / 1ps
// mipmap_box_halving_tb: self-checking bench for the 2x2 box-filter mip downsampler.
// Drives source pixels and register writes, predicts every output word and checks it.
// Depends on mbh_pkg and mipmap_box_halving.
module mipmap_box_halving_tb;
	import mbh_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [PIX_W-1:0] texel;
		logic             frame_end;
	} mip_texel_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [PIX_W-1:0]     s_tdata = '0;     // channel_0, channel_1, channel_2, channel_3
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [PIX_W-1:0]     m_tdata;          // result_0, result_1, result_2, result_3
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	// predictor state
	logic [CFG_DAT_W-1:0] img_w;
	logic [CFG_DAT_W-1:0] img_h;
	logic [NCH_W-1:0]     img_ch;
	logic [11:0]          pos_col;
	logic [11:0]          pos_row;
	logic [PIX_W-1:0]     first_of_pair;
	logic [PSUM_W-1:0]    pair_sum_row [DEF_MAX_WIDTH/2];

	mip_texel_t texels_due[$];
	int mismatches = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;

	mipmap_box_halving dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	function automatic int unsigned clamp_dim(input logic [CFG_DAT_W-1:0] v, input int unsigned top);
		if (v == 0)
			return 1;
		if (v > top)
			return top;
		return 32'(v);
	endfunction

	function automatic void halve_pixel(input logic [PIX_W-1:0] px);
		int unsigned w, h, nch, len, idx, span, span_w, span_h, slot, next_col;
		logic [PIX_W-1:0]  pix;
		logic [PSUM_W-1:0] sums;
		logic [PSUM_W-1:0] above;
		logic [SUM_W-1:0]  pair;
		logic [SUM_W:0]    quad;
		mip_texel_t        t;
		bit                emit;
		w = clamp_dim(img_w, DEF_MAX_WIDTH);
		h = clamp_dim(img_h, DEF_MAX_HEIGHT);
		nch = clamp_dim(CFG_DAT_W'(img_ch), MAX_CHANNELS);
		emit = 1'b0;
		t = '0;
		for (int c = 0; c < NUM_CH; c++)
			pix[c*CH_W +: CH_W] = (c < nch) ? px[c*CH_W +: CH_W] : '0;

		if (w == 1 && h == 1) begin
			t.texel = pix;
			t.frame_end = 1'b1;
			emit = 1'b1;
		end else if (w == 1 || h == 1) begin
			len = (w == 1) ? h : w;
			idx = (w == 1) ? 32'(pos_row) : 32'(pos_col);
			span = (len >> 1) << 1;
			if (idx < span) begin
				if (idx % 2 == 0) begin
					first_of_pair = pix;
				end else begin
					for (int c = 0; c < NUM_CH; c++) begin
						pair = {1'b0, first_of_pair[c*CH_W +: CH_W]}
							+ {1'b0, pix[c*CH_W +: CH_W]};
						t.texel[c*CH_W +: CH_W] = pair[SUM_W-1:1];
					end
					t.frame_end = (idx == span - 1);
					emit = 1'b1;
				end
			end
		end else begin
			span_w = (w >> 1) << 1;
			span_h = (h >> 1) << 1;
			if (pos_col < span_w && pos_row < span_h) begin
				if (pos_col % 2 == 0) begin
					first_of_pair = pix;
				end else begin
					for (int c = 0; c < NUM_CH; c++)
						sums[c*SUM_W +: SUM_W] = {1'b0, first_of_pair[c*CH_W +: CH_W]}
							+ {1'b0, pix[c*CH_W +: CH_W]};
					slot = 32'(pos_col >> 1);
					if (pos_row % 2 == 0) begin
						pair_sum_row[slot] = sums;
					end else begin
						above = pair_sum_row[slot];
						for (int c = 0; c < NUM_CH; c++) begin
							quad = {1'b0, above[c*SUM_W +: SUM_W]}
								+ {1'b0, sums[c*SUM_W +: SUM_W]};
							t.texel[c*CH_W +: CH_W] = quad[SUM_W:2];
						end
						t.frame_end = (pos_row == span_h - 1 && pos_col == span_w - 1);
						emit = 1'b1;
					end
				end
			end
		end

		next_col = pos_col + 1;
		if (next_col >= w) begin
			pos_col = '0;
			if (pos_row + 1 >= h)
				pos_row = '0;
			else
				pos_row = pos_row + 1'b1;
		end else begin
			pos_col = 12'(next_col);
		end
		if (emit)
			texels_due.push_back(t);
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] px);
		if (cfg_valid)
			cfg_valid <= 1'b0;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		halve_pixel(px);
	endtask

	// drop valid, let every due word arrive and the pipe empty out
	task automatic settle();
		s_tvalid <= 1'b0;
		while (texels_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WIDTH:    img_w = value;
			REG_HEIGHT:   img_h = value;
			REG_CHANNELS: img_ch = value[NCH_W-1:0];
			default: ;
		endcase
		if (idx == REG_WIDTH || idx == REG_HEIGHT || idx == REG_CHANNELS) begin
			pos_col = '0;
			pos_row = '0;
		end
	endtask

	task automatic set_geometry(input logic [CFG_DAT_W-1:0] w, input logic [CFG_DAT_W-1:0] h,
			input logic [CFG_DAT_W-1:0] ch);
		settle();
		write_register(REG_WIDTH, w);
		write_register(REG_HEIGHT, h);
		write_register(REG_CHANNELS, ch);
	endtask

	function automatic logic [CFG_DAT_W-1:0] pick_dim(input int unsigned wide_top);
		case ($urandom_range(9))
			0:       return '0;
			1:       return CFG_DAT_W'(1);
			8:       return CFG_DAT_W'($urandom_range(10, wide_top));
			default: return CFG_DAT_W'($urandom_range(2, 9));
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0101_0101);
		send_pixel(32'h00FF_0001);
	endtask

	task automatic test_single_pixel();
		set_geometry(1, 1, 4);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h8040_2010);
		// zero sizes and zero channels fall back to one
		set_geometry(0, 0, 0);
		send_pixel(32'hA5A5_A5A5);
	endtask

	task automatic test_line_modes();
		set_geometry(3, 1, 1);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h1234_5678);
		send_pixel(32'h0000_0001);
		// channel count of seven saturates to four
		set_geometry(1, 2, 13'h1FFF);
		send_pixel(32'h0102_0304);
		send_pixel(32'h0304_0506);
	endtask

	task automatic test_ignored_index();
		set_geometry(2, 2, 4);
		send_pixel(32'hC0DE_0F0F);
		settle();
		write_register(REG_UNUSED, 13'h1FFF);
		send_pixel(32'h1111_2222);
		send_pixel(32'hFFFF_0000);
		send_pixel(32'h7F80_FF01);
	endtask

	task automatic test_largest_sizes();
		// oversize width saturates, so the first row keeps running without a wrap
		set_geometry(13'h1FFF, 13'h1000, 3);
		for (int i = 0; i < 24; i++)
			send_pixel($urandom());
		set_geometry(1, 13'h1FFF, 2);
		for (int i = 0; i < 6; i++)
			send_pixel($urandom());
	endtask

	task automatic test_random_frames(input int budget);
		int sent;
		int unsigned area, n;
		logic [CFG_DAT_W-1:0] w, h;
		sent = 0;
		while (sent < budget) begin
			settle();
			if ($urandom_range(9) != 0) begin
				w = pick_dim(40);
				h = pick_dim(12);
				if ($urandom_range(4) != 0)
					write_register(REG_WIDTH, w);
				if ($urandom_range(4) != 0)
					write_register(REG_HEIGHT, h);
				if ($urandom_range(4) != 0)
					write_register(REG_CHANNELS, CFG_DAT_W'($urandom()));
			end
			area = clamp_dim(img_w, DEF_MAX_WIDTH) * clamp_dim(img_h, DEF_MAX_HEIGHT);
			n = (area > 150) ? area : area * $urandom_range(1, 2);
			if ($urandom_range(3) == 0 && area > 1)
				n += $urandom_range(1, area - 1);
			for (int unsigned i = 0; i < n; i++) begin
				case ($urandom_range(15))
					0:       send_pixel('0);
					1:       send_pixel('1);
					default: send_pixel($urandom());
				endcase
			end
			sent += n;
		end
	endtask

	always @(posedge clk) begin
		mip_texel_t want;
		bit         bad;
		if (arst_n && m_tvalid && m_tready) begin
			if (texels_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: data %08h last %0b", m_tdata, m_tlast);
			end else begin
				want = texels_due.pop_front();
				bad = 1'b0;
				for (int c = 0; c < NUM_CH; c++)
					if (m_tdata[c*CH_W +: CH_W] !== want.texel[c*CH_W +: CH_W])
						bad = 1'b1;
				if (m_tlast !== want.frame_end)
					bad = 1'b1;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected data %08h last %0b, got data %08h last %0b",
							want.texel, want.frame_end, m_tdata, m_tlast);
				end
			end
		end
	end

	initial begin
		img_w = 2;
		img_h = 2;
		img_ch = 4;
		pos_col = '0;
		pos_row = '0;
		first_of_pair = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		src_idle_pct = 33;
		sink_idle_pct = 45;
		test_reset_defaults();
		test_single_pixel();
		test_line_modes();
		test_ignored_index();
		test_largest_sizes();
		test_random_frames(460);

		src_idle_pct = 45;
		sink_idle_pct = 33;
		test_random_frames(460);

		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_random_frames(460);

		settle();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* mipmap_box_halving.f */
sv/mbh_pkg.sv
sv/mipmap_box_halving.sv
sv/mbh_checker.sv
tb/mipmap_box_halving_tb.sv
